// ===== rtl/core/bfsa_pkg.sv =====
// ----------------------------------------------------------------------------
// bfsa_pkg
// Shared widths, codes, types and helpers of the best-fit segment allocator.
// ----------------------------------------------------------------------------
package bfsa_pkg;

  localparam int POOL_BYTES       = 1024 * 1024;
  localparam int MAX_SEGMENTS_DEF = 64;
  localparam int GRANULE_BYTES    = 32;
  localparam int HEADER_BYTES     = 4;

  localparam int MODE_W = 2;
  localparam int ST_W   = 2;
  localparam int OFF_W  = 20;
  localparam int SIZE_W = 21;
  localparam int END_W  = 22;

  localparam logic [MODE_W-1:0] MODE_ALLOC  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FREE   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DEFRAG = 2'd2;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_NOFIT = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic              valid;
    logic [OFF_W-1:0]  start;
    logic [SIZE_W-1:0] size;
  } seg_t;

  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [OFF_W-1:0]  roff;
    logic [SIZE_W-1:0] rsize;
    logic [SIZE_W-1:0] free_bytes;
  } res_t;

  function automatic logic [SIZE_W-1:0] sat_add(input logic [SIZE_W-1:0] a,
                                                 input logic [SIZE_W-1:0] b);
    logic [END_W-1:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s > END_W'(POOL_BYTES)) sat_add = SIZE_W'(POOL_BYTES);
    else sat_add = s[SIZE_W-1:0];
  endfunction

  function automatic logic [END_W-1:0] seg_end(input seg_t s);
    seg_end = {2'b00, s.start} + {1'b0, s.size};
  endfunction

endpackage

// ===== rtl/core/bfsa_cell.sv =====
// ----------------------------------------------------------------------------
// bfsa_cell
// One slot of the segment ring; takes its neighbour's segment on each shift.
// ----------------------------------------------------------------------------
module bfsa_cell #(
  parameter bit INIT_FULL = 1'b0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          shift,
  input  bfsa_pkg::seg_t d,
  output bfsa_pkg::seg_t q
);
  import bfsa_pkg::*;

  seg_t seg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_r.valid <= INIT_FULL;
      seg_r.start <= '0;
      seg_r.size  <= INIT_FULL ? SIZE_W'(POOL_BYTES) : '0;
    end else if (shift) begin
      seg_r <= d;
    end
  end

  assign q = seg_r;

endmodule

// ===== rtl/core/bfsa_ctrl.sv =====
// ----------------------------------------------------------------------------
// bfsa_ctrl
// Sequencer at the head of the ring: scans, edits and merges segments as they
// pass, one segment per cycle, one full turn per pass.
// ----------------------------------------------------------------------------
module bfsa_ctrl #(
  parameter int MAX_SEGMENTS = bfsa_pkg::MAX_SEGMENTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [bfsa_pkg::MODE_W-1:0] in_mode,
  input  logic [bfsa_pkg::OFF_W-1:0]  in_request_size,
  input  logic [bfsa_pkg::OFF_W-1:0]  in_block_offset,
  input  logic [bfsa_pkg::SIZE_W-1:0] in_block_size,
  input  bfsa_pkg::seg_t              head,
  output bfsa_pkg::seg_t              tail,
  output logic                        rotate,
  input  logic                        out_free,
  output logic                        done,
  output bfsa_pkg::res_t              res
);
  import bfsa_pkg::*;

  localparam int PW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CW = $clog2(MAX_SEGMENTS + 1);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_SCAN   = 10'b0000000010,
    S_DECIDE = 10'b0000000100,
    S_APPLY  = 10'b0000001000,
    S_DFETCH = 10'b0000010000,
    S_DSEL   = 10'b0000100000,
    S_DSRCH  = 10'b0001000000,
    S_DDEC   = 10'b0010000000,
    S_DMERGE = 10'b0100000000,
    S_DONE   = 10'b1000000000
  } state_t;

  state_t            state_r, state_nxt;
  logic [PW-1:0]     pos_r, pos_nxt;
  logic [SIZE_W-1:0] total_r, total_nxt;
  logic              found_r, found_nxt;
  logic              exact_r, exact_nxt;
  logic              pend_r, pend_nxt;
  logic              holding_r, holding_nxt;
  logic              nxt_ok_r, nxt_ok_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;

  logic [MODE_W-1:0] mode_r, mode_nxt;
  logic [SIZE_W-1:0] need_r, need_nxt;
  logic [OFF_W-1:0]  boff_r, boff_nxt;
  logic [SIZE_W-1:0] bsize_r, bsize_nxt;
  logic [PW-1:0]     idx_r, idx_nxt;
  logic [SIZE_W-1:0] fsize_r, fsize_nxt;
  logic [OFF_W-1:0]  fstart_r, fstart_nxt;
  seg_t              hold_r, hold_nxt;
  logic [PW-1:0]     ci_r, ci_nxt;
  logic [END_W-1:0]  cend_r, cend_nxt;
  logic [PW-1:0]     nidx_r, nidx_nxt;
  logic [END_W-1:0]  nend_r, nend_nxt;
  logic [ST_W-1:0]   st_r, st_nxt;
  logic [OFF_W-1:0]  roff_r, roff_nxt;
  logic [SIZE_W-1:0] rsize_r, rsize_nxt;

  logic              at_last;
  logic [END_W-1:0]  need_raw;
  logic [SIZE_W-1:0] diff;
  logic              lat_en;

  assign at_last  = (pos_r == PW'(MAX_SEGMENTS - 1));
  assign in_stall = (state_r != S_IDLE);
  assign rotate   = (state_r == S_SCAN) || (state_r == S_APPLY) || (state_r == S_DFETCH) ||
                    (state_r == S_DSRCH) || (state_r == S_DMERGE);
  assign need_raw = ({2'b00, in_request_size} + END_W'(HEADER_BYTES + GRANULE_BYTES - 1)) &
                    ~END_W'(GRANULE_BYTES - 1);
  assign diff     = fsize_r - need_r;

  assign done             = (state_r == S_DONE) && out_free;
  assign res.status       = st_r;
  assign res.roff         = roff_r;
  assign res.rsize        = rsize_r;
  assign res.free_bytes   = total_r;

  always_comb begin
    state_nxt   = state_r;
    pos_nxt     = rotate ? (at_last ? '0 : pos_r + PW'(1)) : pos_r;
    total_nxt   = total_r;
    found_nxt   = found_r;
    exact_nxt   = exact_r;
    pend_nxt    = pend_r;
    holding_nxt = holding_r;
    nxt_ok_nxt  = nxt_ok_r;
    cnt_nxt     = cnt_r;
    mode_nxt    = mode_r;
    need_nxt    = need_r;
    boff_nxt    = boff_r;
    bsize_nxt   = bsize_r;
    idx_nxt     = idx_r;
    fsize_nxt   = fsize_r;
    fstart_nxt  = fstart_r;
    hold_nxt    = hold_r;
    ci_nxt      = ci_r;
    cend_nxt    = cend_r;
    nidx_nxt    = nidx_r;
    nend_nxt    = nend_r;
    st_nxt      = st_r;
    roff_nxt    = roff_r;
    rsize_nxt   = rsize_r;
    tail        = head;
    lat_en      = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          mode_nxt  = in_mode;
          need_nxt  = need_raw[SIZE_W-1:0];
          boff_nxt  = in_block_offset;
          bsize_nxt = in_block_size;
          st_nxt    = ST_OK;
          roff_nxt  = '0;
          rsize_nxt = '0;
          found_nxt = 1'b0;
          exact_nxt = 1'b0;
          cnt_nxt   = '0;
          nxt_ok_nxt = 1'b0;
          if (in_mode == MODE_ALLOC || in_mode == MODE_FREE) state_nxt = S_SCAN;
          else if (in_mode == MODE_DEFRAG) state_nxt = S_DFETCH;
          else state_nxt = S_DONE;
        end
      end
      S_SCAN: begin
        if (head.valid) begin
          cnt_nxt = cnt_r + CW'(1);
          if (mode_r == MODE_ALLOC) begin
            if (!exact_r) begin
              if (head.size == need_r) begin
                exact_nxt  = 1'b1;
                idx_nxt    = pos_r;
                fstart_nxt = head.start;
              end else if (head.size > need_r && (!found_r || head.size < fsize_r)) begin
                found_nxt  = 1'b1;
                idx_nxt    = pos_r;
                fsize_nxt  = head.size;
                fstart_nxt = head.start;
              end
            end
          end else if (!found_r && seg_end(head) == {2'b00, boff_r}) begin
            found_nxt = 1'b1;
            idx_nxt   = pos_r;
          end
        end
        if (at_last) state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        if (mode_r == MODE_ALLOC) begin
          if (exact_r || found_r) begin
            roff_nxt  = exact_r ? fstart_r : fstart_r + diff[OFF_W-1:0];
            rsize_nxt = need_r;
            total_nxt = (total_r > need_r) ? total_r - need_r : '0;
            state_nxt = S_APPLY;
          end else begin
            st_nxt    = ST_NOFIT;
            state_nxt = S_DONE;
          end
        end else begin
          if (!found_r && cnt_r == CW'(MAX_SEGMENTS)) begin
            st_nxt    = ST_FULL;
            state_nxt = S_DONE;
          end else begin
            pend_nxt    = !found_r;
            holding_nxt = 1'b0;
            total_nxt   = sat_add(total_r, bsize_r);
            state_nxt   = S_APPLY;
          end
        end
      end
      S_APPLY: begin
        if (mode_r == MODE_ALLOC) begin
          if (pos_r == idx_r) begin
            if (exact_r) tail.valid = 1'b0;
            else tail.size = head.size - need_r;
          end
        end else if (found_r) begin
          if (pos_r == idx_r) tail.size = sat_add(head.size, bsize_r);
        end else if (pend_r) begin
          tail.valid = 1'b1;
          tail.start = boff_r;
          tail.size  = (bsize_r > SIZE_W'(POOL_BYTES)) ? SIZE_W'(POOL_BYTES) : bsize_r;
          pend_nxt   = 1'b0;
          if (head.valid) begin
            hold_nxt    = head;
            holding_nxt = 1'b1;
          end
        end else if (holding_r) begin
          tail = hold_r;
          if (head.valid) hold_nxt = head;
          else holding_nxt = 1'b0;
        end
        if (at_last) state_nxt = S_DONE;
      end
      S_DFETCH: begin
        lat_en = head.valid;
        if (at_last) state_nxt = S_DSEL;
      end
      S_DSEL: begin
        if (!nxt_ok_r) begin
          state_nxt = S_DONE;
        end else begin
          ci_nxt     = nidx_r;
          cend_nxt   = nend_r;
          found_nxt  = 1'b0;
          nxt_ok_nxt = 1'b0;
          state_nxt  = S_DSRCH;
        end
      end
      S_DSRCH: begin
        if (head.valid && pos_r != ci_r && !found_r && {2'b00, head.start} == cend_r) begin
          found_nxt = 1'b1;
          idx_nxt   = pos_r;
          fsize_nxt = head.size;
        end
        lat_en = head.valid && (pos_r > ci_r);
        if (at_last) state_nxt = S_DDEC;
      end
      S_DDEC: begin
        if (found_r) begin
          nxt_ok_nxt = 1'b0;
          state_nxt  = S_DMERGE;
        end else begin
          state_nxt = S_DSEL;
        end
      end
      S_DMERGE: begin
        if (pos_r == ci_r) tail.size = sat_add(head.size, fsize_r);
        if (pos_r == idx_r) tail.valid = 1'b0;
        lat_en = tail.valid;
        if (at_last) state_nxt = S_DSEL;
      end
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase

    if (lat_en && !nxt_ok_r) begin
      nxt_ok_nxt = 1'b1;
      nidx_nxt   = pos_r;
      nend_nxt   = seg_end(tail);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      pos_r     <= '0;
      total_r   <= SIZE_W'(POOL_BYTES);
      found_r   <= 1'b0;
      exact_r   <= 1'b0;
      pend_r    <= 1'b0;
      holding_r <= 1'b0;
      nxt_ok_r  <= 1'b0;
      cnt_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      pos_r     <= pos_nxt;
      total_r   <= total_nxt;
      found_r   <= found_nxt;
      exact_r   <= exact_nxt;
      pend_r    <= pend_nxt;
      holding_r <= holding_nxt;
      nxt_ok_r  <= nxt_ok_nxt;
      cnt_r     <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r   <= mode_nxt;
    need_r   <= need_nxt;
    boff_r   <= boff_nxt;
    bsize_r  <= bsize_nxt;
    idx_r    <= idx_nxt;
    fsize_r  <= fsize_nxt;
    fstart_r <= fstart_nxt;
    hold_r   <= hold_nxt;
    ci_r     <= ci_nxt;
    cend_r   <= cend_nxt;
    nidx_r   <= nidx_nxt;
    nend_r   <= nend_nxt;
    st_r     <= st_nxt;
    roff_r   <= roff_nxt;
    rsize_r  <= rsize_nxt;
  end

endmodule

// ===== rtl/core/best_fit_segment_allocator.sv =====
// ----------------------------------------------------------------------------
// best_fit_segment_allocator
// Free-segment table kept in a rotating ring of cells with a sequencer at the
// head; allocate, free and defragment a pool, reporting free bytes.
// ----------------------------------------------------------------------------
// Allocate and free each take a scan turn and an edit turn of the ring;
//   table-full and no-fit stop after the scan turn.
// Defragment takes one fetch turn, then a search turn per candidate and a
//   merge turn per merge. One word is in work at a time.
// Reset: synchronous; the ring holds one segment covering the whole pool.
module best_fit_segment_allocator #(
  parameter int MAX_SEGMENTS = bfsa_pkg::MAX_SEGMENTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [bfsa_pkg::MODE_W-1:0] in_mode,
  input  logic [bfsa_pkg::OFF_W-1:0]  in_request_size,
  input  logic [bfsa_pkg::OFF_W-1:0]  in_block_offset,
  input  logic [bfsa_pkg::SIZE_W-1:0] in_block_size,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [bfsa_pkg::ST_W-1:0]   out_status,
  output logic [bfsa_pkg::OFF_W-1:0]  out_result_offset,
  output logic [bfsa_pkg::SIZE_W-1:0] out_result_size,
  output logic [bfsa_pkg::SIZE_W-1:0] out_free_bytes
);
  import bfsa_pkg::*;

  seg_t ring [MAX_SEGMENTS];
  seg_t tail;
  logic rotate;
  logic done;
  logic out_free;
  res_t res;
  res_t out_r;
  logic out_valid_r;

  for (genvar k = 0; k < MAX_SEGMENTS; k++) begin : g_cell
    bfsa_cell #(
      .INIT_FULL(k == 0)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .shift (rotate),
      .d     ((k == MAX_SEGMENTS - 1) ? tail : ring[(k + 1) % MAX_SEGMENTS]),
      .q     (ring[k])
    );
  end

  bfsa_ctrl #(
    .MAX_SEGMENTS(MAX_SEGMENTS)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_mode         (in_mode),
    .in_request_size (in_request_size),
    .in_block_offset (in_block_offset),
    .in_block_size   (in_block_size),
    .head            (ring[0]),
    .tail            (tail),
    .rotate          (rotate),
    .out_free        (out_free),
    .done            (done),
    .res             (res)
  );

  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) out_r <= res;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_r.status;
  assign out_result_offset = out_r.roff;
  assign out_result_size   = out_r.rsize;
  assign out_free_bytes    = out_r.free_bytes;

  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_free_bytes <= SIZE_W'(POOL_BYTES))
    else $error("free byte count above pool size");

  a_nofit_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_result_size == '0 && out_result_offset == '0)
    else $error("failed request reports a block");

  a_granule: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_result_size & SIZE_W'(GRANULE_BYTES - 1)) == '0)
    else $error("allocated size not a whole number of granules");

  a_busy_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    rotate |-> !done)
    else $error("result issued mid-turn");

endmodule
